// ===== rtl/geic_pkg.sv =====
// Shared types and constants for the GPIO edge interrupt controller.
// Depends on nothing; every other file refers to it by scoped names.
package geic_pkg;

	localparam int NumPins  = 30;
	localparam int PinIdxW  = (NumPins > 1) ? $clog2(NumPins) : 1;
	localparam int FlatW    = 5;
	localparam int PortW    = 3;
	localparam int PinInW   = 4;
	localparam int PinW     = 3;
	localparam int LevelW   = 30;
	localparam int CmdDepth = 2;
	localparam int CmdPtrW  = (CmdDepth > 1) ? $clog2(CmdDepth) : 1;
	localparam int CmdCntW  = $clog2(CmdDepth + 1);

	// bit positions inside a two-bit edge mask
	localparam int EdgeFall = 0;
	localparam int EdgeRise = 1;

	typedef enum logic [1:0] {
		ACT_ENABLE  = 2'd0,
		ACT_DISABLE = 2'd1,
		ACT_SAMPLE  = 2'd2,
		ACT_SERVICE = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		SEL_RISE    = 2'd0,
		SEL_FALL    = 2'd1,
		SEL_BOTH    = 2'd2,
		SEL_UNKNOWN = 2'd3
	} edge_sel_t;

	typedef enum logic [0:0] {
		BK_IDLE = 1'b0,
		BK_SCAN = 1'b1
	} back_state_t;

	typedef struct packed {
		action_t             op;
		logic                bad;
		logic [FlatW-1:0]    idx;
		logic [1:0]          bits;
		logic [LevelW-1:0]   levels;
	} cmd_t;

	typedef struct packed {
		logic             kind;
		logic             status;
		logic             found;
		logic [PortW-1:0] port;
		logic [PinW-1:0]  pin;
		logic             last;
	} res_t;

endpackage

// ===== rtl/geic_front.sv =====
// Front end: decodes and validates an incoming transaction into a command.
// Depends on geic_pkg.
module geic_front (
	input  logic [1:0]                  action,
	input  logic [geic_pkg::PortW-1:0]  port,
	input  logic [geic_pkg::PinInW-1:0] pin,
	input  logic [1:0]                  edge_select,
	input  logic [geic_pkg::LevelW-1:0] pin_levels,
	output geic_pkg::cmd_t              cmd
);

	logic                       addr_ok;
	logic [geic_pkg::FlatW-1:0] flat;
	logic [1:0]                 bits;
	logic [1:0]                 port_m1;
	geic_pkg::action_t          op;

	assign op      = geic_pkg::action_t'(action);
	assign port_m1 = 2'(port - geic_pkg::PortW'(1));
	assign flat    = {port_m1, pin[geic_pkg::PinW-1:0]};

	always_comb begin
		addr_ok = (port >= geic_pkg::PortW'(1)) && (port <= geic_pkg::PortW'(4))
			&& (pin <= geic_pkg::PinInW'(7))
			&& ({1'b0, flat} < 6'(geic_pkg::NumPins));
	end

	always_comb begin
		bits = 2'b00;
		case (geic_pkg::edge_sel_t'(edge_select))
			geic_pkg::SEL_RISE: bits[geic_pkg::EdgeRise] = 1'b1;
			geic_pkg::SEL_FALL: bits[geic_pkg::EdgeFall] = 1'b1;
			geic_pkg::SEL_BOTH: bits = 2'b11;
			default: bits = 2'b00;
		endcase
	end

	always_comb begin
		cmd.op     = op;
		cmd.idx    = flat;
		cmd.bits   = bits;
		cmd.levels = pin_levels;
		case (op)
			geic_pkg::ACT_ENABLE:  cmd.bad = !addr_ok || (bits == 2'b00);
			geic_pkg::ACT_DISABLE: cmd.bad = !addr_ok;
			default:               cmd.bad = 1'b0;
		endcase
	end

endmodule

// ===== rtl/geic_cmd_fifo.sv =====
// Short command queue between the front end and the execution back end.
// Depends on geic_pkg.
module geic_cmd_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  geic_pkg::cmd_t push_data,
	output logic           full,
	input  logic           pop,
	output logic           not_empty,
	output geic_pkg::cmd_t head
);

	geic_pkg::cmd_t                mem [geic_pkg::CmdDepth];
	logic [geic_pkg::CmdPtrW-1:0]  wr_ptr_q;
	logic [geic_pkg::CmdPtrW-1:0]  rd_ptr_q;
	logic [geic_pkg::CmdCntW-1:0]  count_q;
	logic                          do_push;
	logic                          do_pop;

	assign full      = (count_q == geic_pkg::CmdCntW'(geic_pkg::CmdDepth));
	assign not_empty = (count_q != '0);
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign head      = mem[rd_ptr_q];

	function automatic logic [geic_pkg::CmdPtrW-1:0] ptr_inc(
		input logic [geic_pkg::CmdPtrW-1:0] p);
		if (p == geic_pkg::CmdPtrW'(geic_pkg::CmdDepth - 1))
			return '0;
		return p + geic_pkg::CmdPtrW'(1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			if (do_pop)
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			if (do_push && !do_pop)
				count_q <= count_q + geic_pkg::CmdCntW'(1);
			else if (do_pop && !do_push)
				count_q <= count_q - geic_pkg::CmdCntW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			mem[wr_ptr_q] <= push_data;
	end

endmodule

// ===== rtl/geic_back.sv =====
// Back end: holds the per-pin enable and latch state, executes commands and
// scans pending pins one per cycle, while the output is free, for service. Depends on geic_pkg.
module geic_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	input  geic_pkg::cmd_t cmd,
	output logic           cmd_pop,
	output logic           res_valid,
	input  logic           res_ready,
	output geic_pkg::res_t res
);

	localparam int N = geic_pkg::NumPins;

	geic_pkg::back_state_t          state_q, state_d;
	logic [N-1:0]                   en_rise_q, en_fall_q, latch_rise_q, latch_fall_q;
	logic [N-1:0]                   en_rise_d, en_fall_d, latch_rise_d, latch_fall_d;
	logic [N-1:0]                   prev_q, prev_d;
	logic [N-1:0]                   hits_q, hits_d;
	logic [geic_pkg::PinIdxW-1:0]   scan_q, scan_d;
	logic                           res_valid_q;
	geic_pkg::res_t                 res_q, res_d;
	logic                           emit;
	logic                           out_free;

	logic [N-1:0] hit_rise, hit_fall, hit_vec, remain, now;
	logic         hit_any, scan_hit, remain_zero;
	logic [geic_pkg::FlatW-1:0] scan_flat;

	assign out_free    = !res_valid_q || res_ready;
	assign hit_rise    = latch_rise_q & en_rise_q;
	assign hit_fall    = latch_fall_q & en_fall_q;
	assign hit_vec     = hit_rise | hit_fall;
	assign hit_any     = |hit_vec;
	assign scan_hit    = hits_q[scan_q];
	assign remain      = hits_q & ~(N'(1) << scan_q);
	assign remain_zero = ~|remain;
	assign scan_flat   = geic_pkg::FlatW'(scan_q);

	always_comb begin
		for (int i = 0; i < N; i++) begin
			if (i < geic_pkg::LevelW)
				now[i] = cmd.levels[i];
			else
				now[i] = 1'b0;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			geic_pkg::BK_IDLE: begin
				if (cmd_valid && out_free && cmd.op == geic_pkg::ACT_SERVICE && hit_any)
					state_d = geic_pkg::BK_SCAN;
			end
			geic_pkg::BK_SCAN: begin
				if (out_free && scan_hit && remain_zero)
					state_d = geic_pkg::BK_IDLE;
			end
			default: state_d = geic_pkg::BK_IDLE;
		endcase
	end

	// command execution and result generation
	always_comb begin
		cmd_pop      = 1'b0;
		emit         = 1'b0;
		res_d        = '0;
		en_rise_d    = en_rise_q;
		en_fall_d    = en_fall_q;
		latch_rise_d = latch_rise_q;
		latch_fall_d = latch_fall_q;
		prev_d       = prev_q;
		hits_d       = hits_q;
		scan_d       = scan_q;
		case (state_q)
			geic_pkg::BK_IDLE: begin
				if (cmd_valid) begin
					case (cmd.op)
						geic_pkg::ACT_ENABLE: begin
							if (out_free) begin
								cmd_pop      = 1'b1;
								emit         = 1'b1;
								res_d.status = cmd.bad;
								res_d.last   = 1'b1;
								for (int i = 0; i < N; i++) begin
									if (!cmd.bad && cmd.idx == geic_pkg::FlatW'(i)) begin
										if (cmd.bits[geic_pkg::EdgeRise]) begin
											latch_rise_d[i] = 1'b0;
											en_rise_d[i]    = 1'b1;
										end
										if (cmd.bits[geic_pkg::EdgeFall]) begin
											latch_fall_d[i] = 1'b0;
											en_fall_d[i]    = 1'b1;
										end
									end
								end
							end
						end
						geic_pkg::ACT_DISABLE: begin
							if (out_free) begin
								cmd_pop      = 1'b1;
								emit         = 1'b1;
								res_d.status = cmd.bad;
								res_d.last   = 1'b1;
								for (int i = 0; i < N; i++) begin
									if (!cmd.bad && cmd.idx == geic_pkg::FlatW'(i)) begin
										en_rise_d[i]    = 1'b0;
										en_fall_d[i]    = 1'b0;
										latch_rise_d[i] = 1'b0;
										latch_fall_d[i] = 1'b0;
									end
								end
							end
						end
						geic_pkg::ACT_SAMPLE: begin
							cmd_pop      = 1'b1;
							latch_rise_d = latch_rise_q | (now & ~prev_q);
							latch_fall_d = latch_fall_q | (~now & prev_q);
							prev_d       = now;
						end
						geic_pkg::ACT_SERVICE: begin
							if (out_free) begin
								cmd_pop = 1'b1;
								if (hit_any) begin
									// clear what will be reported, then walk the snapshot
									latch_rise_d = latch_rise_q & ~hit_rise;
									latch_fall_d = latch_fall_q & ~hit_fall;
									hits_d       = hit_vec;
									scan_d       = '0;
								end else begin
									emit       = 1'b1;
									res_d.kind = 1'b1;
									res_d.last = 1'b1;
								end
							end
						end
						default: ;
					endcase
				end
			end
			geic_pkg::BK_SCAN: begin
				if (out_free) begin
					scan_d = scan_q + geic_pkg::PinIdxW'(1);
					if (scan_hit) begin
						emit        = 1'b1;
						res_d.kind  = 1'b1;
						res_d.found = 1'b1;
						res_d.port  = {1'b0, scan_flat[4:3]} + geic_pkg::PortW'(1);
						res_d.pin   = scan_flat[geic_pkg::PinW-1:0];
						res_d.last  = remain_zero;
						hits_d      = remain;
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= geic_pkg::BK_IDLE;
			en_rise_q    <= '0;
			en_fall_q    <= '0;
			latch_rise_q <= '0;
			latch_fall_q <= '0;
			prev_q       <= '0;
			hits_q       <= '0;
			scan_q       <= '0;
			res_valid_q  <= 1'b0;
		end else begin
			state_q      <= state_d;
			en_rise_q    <= en_rise_d;
			en_fall_q    <= en_fall_d;
			latch_rise_q <= latch_rise_d;
			latch_fall_q <= latch_fall_d;
			prev_q       <= prev_d;
			hits_q       <= hits_d;
			scan_q       <= scan_d;
			if (emit)
				res_valid_q <= 1'b1;
			else if (res_ready)
				res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit)
			res_q <= res_d;
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

// ===== rtl/gpio_edge_interrupt_controller_top.sv =====
// Top level of the GPIO edge interrupt controller: front end, command queue
// and back end. Depends on geic_pkg, geic_front, geic_cmd_fifo, geic_back.
//
//  channel  handshake           payload
//  in       in_valid/in_ready   action, port, pin, edge_select, pin_levels
//  out      out_valid/out_ready kind, status, found, event_port, event_pin, last
//
// Enable and disable each load the output register when they execute;
// sample loads no result. Service snapshots and clears the pending bits, or
// replies none-pending if there are none; then the pin counter walks one pin a
// cycle, while the output is free, up to the last pending pin.
// A two-entry queue decouples input from execution; in_ready drops only
// when it is full. A stalled output holds the back end for all but sample, nothing is lost.
// Reset clears all enable, latch and level state at once.
module gpio_edge_interrupt_controller_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [1:0]                  action,
	input  logic [geic_pkg::PortW-1:0]  port,
	input  logic [geic_pkg::PinInW-1:0] pin,
	input  logic [1:0]                  edge_select,
	input  logic [geic_pkg::LevelW-1:0] pin_levels,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic                        kind,
	output logic                        status,
	output logic                        found,
	output logic [geic_pkg::PortW-1:0]  event_port,
	output logic [geic_pkg::PinW-1:0]   event_pin,
	output logic                        last
);

	geic_pkg::cmd_t front_cmd;
	geic_pkg::cmd_t head_cmd;
	geic_pkg::res_t res;
	logic           fifo_full;
	logic           fifo_not_empty;
	logic           cmd_pop;

	geic_front u_front (
		.action      (action),
		.port        (port),
		.pin         (pin),
		.edge_select (edge_select),
		.pin_levels  (pin_levels),
		.cmd         (front_cmd)
	);

	geic_cmd_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (in_valid),
		.push_data (front_cmd),
		.full      (fifo_full),
		.pop       (cmd_pop),
		.not_empty (fifo_not_empty),
		.head      (head_cmd)
	);

	geic_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (fifo_not_empty),
		.cmd       (head_cmd),
		.cmd_pop   (cmd_pop),
		.res_valid (out_valid),
		.res_ready (out_ready),
		.res       (res)
	);

	assign in_ready   = !fifo_full;
	assign kind       = res.kind;
	assign status     = res.status;
	assign found      = res.found;
	assign event_port = res.port;
	assign event_pin  = res.pin;
	assign last       = res.last;

endmodule

// ===== test/gpio_edge_interrupt_controller_top_tb.sv =====
// Self-checking testbench for gpio_edge_interrupt_controller_top: a directed table,
// then random traffic with idling on both sides, checked against a local predictor.
// Depends on geic_pkg and the RTL under rtl/.
module gpio_edge_interrupt_controller_top_tb;

	localparam int RandItems = 96;
	localparam int CycleLimit = 600000;
	localparam int LongHold = 300;
	localparam int SettleCycles = 40;

	typedef struct packed {
		geic_pkg::action_t                 act;
		logic [geic_pkg::PortW-1:0]        port;
		logic [geic_pkg::PinInW-1:0]       pin;
		geic_pkg::edge_sel_t               sel;
		logic [geic_pkg::LevelW-1:0]       lv;
		logic                              typed;
		geic_pkg::res_t                    want;
	} row_t;

	localparam geic_pkg::res_t ReplyOk     = {1'b0, 1'b0, 1'b0, 3'd0, 3'd0, 1'b1};
	localparam geic_pkg::res_t ReplyBad    = {1'b0, 1'b1, 1'b0, 3'd0, 3'd0, 1'b1};
	localparam geic_pkg::res_t NonePending = {1'b1, 1'b0, 1'b0, 3'd0, 3'd0, 1'b1};
	localparam geic_pkg::res_t NoRes       = '0;
	localparam logic [geic_pkg::LevelW-1:0] LvZero = '0;
	localparam logic [geic_pkg::LevelW-1:0] LvOnes = '1;
	localparam logic [geic_pkg::LevelW-1:0] LvMixed = 30'h2AAA_5555;

	// typed rows carry their reply; the rest go through the predictor
	localparam int NDir = 24;
	localparam row_t DirectedRows [NDir] = '{
		{geic_pkg::ACT_SERVICE, 3'd0, 4'd0, geic_pkg::SEL_RISE, LvZero, 1'b1, NonePending},
		{geic_pkg::ACT_ENABLE, 3'd0, 4'd0, geic_pkg::SEL_RISE, LvZero, 1'b1, ReplyBad},
		{geic_pkg::ACT_ENABLE, 3'd5, 4'd0, geic_pkg::SEL_RISE, LvZero, 1'b1, ReplyBad},
		{geic_pkg::ACT_ENABLE, 3'd7, 4'd15, geic_pkg::SEL_FALL, LvOnes, 1'b1, ReplyBad},
		{geic_pkg::ACT_ENABLE, 3'd1, 4'd8, geic_pkg::SEL_BOTH, LvZero, 1'b1, ReplyBad},
		{geic_pkg::ACT_ENABLE, 3'd4, 4'd6, geic_pkg::SEL_RISE, LvZero, 1'b1, ReplyBad},
		{geic_pkg::ACT_DISABLE, 3'd4, 4'd7, geic_pkg::SEL_RISE, LvZero, 1'b1, ReplyBad},
		{geic_pkg::ACT_DISABLE, 3'd0, 4'd3, geic_pkg::SEL_BOTH, LvZero, 1'b1, ReplyBad},
		{geic_pkg::ACT_ENABLE, 3'd1, 4'd0, geic_pkg::SEL_UNKNOWN, LvZero, 1'b1, ReplyBad},
		{geic_pkg::ACT_ENABLE, 3'd1, 4'd0, geic_pkg::SEL_RISE, LvZero, 1'b1, ReplyOk},
		{geic_pkg::ACT_ENABLE, 3'd4, 4'd5, geic_pkg::SEL_FALL, LvZero, 1'b1, ReplyOk},
		{geic_pkg::ACT_ENABLE, 3'd2, 4'd3, geic_pkg::SEL_BOTH, LvZero, 1'b1, ReplyOk},
		{geic_pkg::ACT_ENABLE, 3'd1, 4'd0, geic_pkg::SEL_FALL, LvZero, 1'b1, ReplyOk},
		{geic_pkg::ACT_SAMPLE, 3'd0, 4'd0, geic_pkg::SEL_RISE, LvOnes, 1'b0, NoRes},
		{geic_pkg::ACT_SERVICE, 3'd7, 4'd15, geic_pkg::SEL_UNKNOWN, LvZero, 1'b0, NoRes},
		{geic_pkg::ACT_SERVICE, 3'd0, 4'd0, geic_pkg::SEL_RISE, LvZero, 1'b1, NonePending},
		{geic_pkg::ACT_SAMPLE, 3'd5, 4'd9, geic_pkg::SEL_BOTH, LvZero, 1'b0, NoRes},
		{geic_pkg::ACT_ENABLE, 3'd3, 4'd7, geic_pkg::SEL_RISE, LvOnes, 1'b1, ReplyOk},
		{geic_pkg::ACT_SERVICE, 3'd0, 4'd0, geic_pkg::SEL_RISE, LvZero, 1'b0, NoRes},
		{geic_pkg::ACT_DISABLE, 3'd1, 4'd0, geic_pkg::SEL_UNKNOWN, LvOnes, 1'b1, ReplyOk},
		{geic_pkg::ACT_SAMPLE, 3'd0, 4'd0, geic_pkg::SEL_RISE, LvOnes, 1'b0, NoRes},
		{geic_pkg::ACT_ENABLE, 3'd2, 4'd3, geic_pkg::SEL_RISE, LvZero, 1'b1, ReplyOk},
		{geic_pkg::ACT_SERVICE, 3'd0, 4'd0, geic_pkg::SEL_RISE, LvZero, 1'b0, NoRes},
		{geic_pkg::ACT_DISABLE, 3'd4, 4'd5, geic_pkg::SEL_BOTH, LvMixed, 1'b1, ReplyOk}
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] action = '0;
	logic [geic_pkg::PortW-1:0] port = '0;
	logic [geic_pkg::PinInW-1:0] pin = '0;
	logic [1:0] edge_select = '0;
	logic [geic_pkg::LevelW-1:0] pin_levels = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic kind;
	logic status;
	logic found;
	logic [geic_pkg::PortW-1:0] event_port;
	logic [geic_pkg::PinW-1:0] event_pin;
	logic last;

	// predictor state
	logic [1:0] en_mask [geic_pkg::NumPins];
	logic [1:0] latched [geic_pkg::NumPins];
	logic [geic_pkg::LevelW-1:0] prev_lv = '0;
	geic_pkg::res_t replies_due [$];

	bit no_idle = 1'b0;
	bit long_hold_req = 1'b0;
	int items_sent = 0;
	int replies_seen = 0;
	int events_seen = 0;
	int busiest = 0;
	int mismatches = 0;
	int cycles = 0;
	geic_pkg::res_t got_res;
	geic_pkg::res_t want_res;

	gpio_edge_interrupt_controller_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.action(action),
		.port(port),
		.pin(pin),
		.edge_select(edge_select),
		.pin_levels(pin_levels),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.kind(kind),
		.status(status),
		.found(found),
		.event_port(event_port),
		.event_pin(event_pin),
		.last(last)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	initial begin
		for (int n = 0; n < geic_pkg::NumPins; n++) begin
			en_mask[n] = '0;
			latched[n] = '0;
		end
	end

	// mostly back-to-back, some short gaps, the odd long one
	function automatic int idle_len();
		int p;
		p = $urandom_range(0, 99);
		if (p < 75)
			return 0;
		else if (p < 95)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 40);
	endfunction

	function automatic int flat_of(logic [geic_pkg::PortW-1:0] po,
		logic [geic_pkg::PinInW-1:0] pi);
		int f;
		if (po < 1 || po > 4 || pi > 7)
			return -1;
		f = (int'(po) - 1) * 8 + int'(pi);
		if (f >= geic_pkg::NumPins)
			return -1;
		return f;
	endfunction

	function automatic logic [1:0] edge_mask(geic_pkg::edge_sel_t s);
		logic [1:0] m;
		m = '0;
		case (s)
			geic_pkg::SEL_RISE: m[geic_pkg::EdgeRise] = 1'b1;
			geic_pkg::SEL_FALL: m[geic_pkg::EdgeFall] = 1'b1;
			geic_pkg::SEL_BOTH: m = 2'b11;
			default: m = '0;
		endcase
		return m;
	endfunction

	task automatic predict_replies(row_t r);
		int idx;
		int hits;
		logic [1:0] sel_bits;
		logic [1:0] hit;
		geic_pkg::res_t tail;
		idx = flat_of(r.port, r.pin);
		case (r.act)
			geic_pkg::ACT_ENABLE: begin
				sel_bits = edge_mask(r.sel);
				if (idx < 0 || sel_bits == 2'b00) begin
					replies_due.push_back(ReplyBad);
				end else begin
					latched[idx] = latched[idx] & ~sel_bits;
					en_mask[idx] = en_mask[idx] | sel_bits;
					replies_due.push_back(ReplyOk);
				end
			end
			geic_pkg::ACT_DISABLE: begin
				if (idx < 0) begin
					replies_due.push_back(ReplyBad);
				end else begin
					en_mask[idx] = '0;
					latched[idx] = '0;
					replies_due.push_back(ReplyOk);
				end
			end
			geic_pkg::ACT_SAMPLE: begin
				for (int n = 0; n < geic_pkg::NumPins; n++) begin
					if (r.lv[n] && !prev_lv[n])
						latched[n][geic_pkg::EdgeRise] = 1'b1;
					if (!r.lv[n] && prev_lv[n])
						latched[n][geic_pkg::EdgeFall] = 1'b1;
				end
				prev_lv = r.lv;
			end
			default: begin
				hits = 0;
				for (int n = 0; n < geic_pkg::NumPins; n++) begin
					hit = latched[n] & en_mask[n];
					if (hit != 2'b00) begin
						replies_due.push_back({1'b1, 1'b0, 1'b1, 3'(n / 8 + 1), 3'(n % 8), 1'b0});
						latched[n] = latched[n] & ~hit;
						hits++;
					end
				end
				if (hits == 0) begin
					replies_due.push_back(NonePending);
				end else begin
					tail = replies_due.pop_back();
					tail.last = 1'b1;
					replies_due.push_back(tail);
				end
				if (hits > busiest)
					busiest = hits;
			end
		endcase
	endtask

	function automatic row_t random_row();
		row_t r;
		int f;
		int p;
		r = '0;
		p = $urandom_range(0, 99);
		r.act = (p < 30) ? geic_pkg::ACT_ENABLE : (p < 40) ? geic_pkg::ACT_DISABLE :
			(p < 72) ? geic_pkg::ACT_SAMPLE : geic_pkg::ACT_SERVICE;
		if ($urandom_range(0, 6) == 0) begin
			r.port = 3'($urandom_range(0, 7));
			r.pin = 4'($urandom_range(0, 15));
		end else begin
			f = $urandom_range(0, geic_pkg::NumPins - 1);
			r.port = 3'(f / 8 + 1);
			r.pin = 4'(f % 8);
		end
		if ($urandom_range(0, 9) == 0)
			r.sel = geic_pkg::SEL_UNKNOWN;
		else
			r.sel = geic_pkg::edge_sel_t'(2'($urandom_range(0, 2)));
		r.lv = 30'($urandom());
		return r;
	endfunction

	// one input transaction; returns at the edge where it is taken
	task automatic offer(row_t r);
		int gap;
		geic_pkg::res_t dummy;
		gap = no_idle ? 0 : idle_len();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		action <= r.act;
		port <= r.port;
		pin <= r.pin;
		edge_select <= r.sel;
		pin_levels <= r.lv;
		do @(posedge clk); while (!in_ready);
		predict_replies(r);
		if (r.typed) begin
			dummy = replies_due.pop_back();
			replies_due.push_back(r.want);
		end
		items_sent++;
	endtask

	initial begin : drive_items
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int k = 0; k < NDir; k++)
			offer(DirectedRows[k]);
		for (int k = 0; k < RandItems; k++) begin
			// starve the output while items keep coming, so the queue fills
			if (k == 15)
				long_hold_req = 1'b1;
			if (k == 60) begin
				in_valid <= 1'b0;
				do @(posedge clk); while (replies_due.size() != 0);
			end
			no_idle = (k >= 80 && k < 100);
			offer(random_row());
		end
		no_idle = 1'b0;
		in_valid <= 1'b0;
		do @(posedge clk); while (replies_due.size() != 0);
		repeat (SettleCycles) @(posedge clk);
		$display("Covered %0d input transactions: %0d status replies, %0d pin events,",
			items_sent, replies_seen, events_seen);
		$display("busiest service gave %0d events; one long output stall of %0d cycles.",
			busiest, LongHold);
		if (mismatches == 0)
			$display("PASS gpio_edge_interrupt_controller_top");
		else
			$display("FAIL gpio_edge_interrupt_controller_top");
		$finish;
	end

	initial begin : accept_results
		int hold;
		hold = 0;
		forever begin
			@(posedge clk);
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				hold = LongHold;
			end else if (hold == 0 && !no_idle) begin
				hold = idle_len();
			end
			if (hold > 0) begin
				hold--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	function automatic void check_field(string name, int want_v, int got_v);
		if (want_v != got_v) begin
			$error("%s: expected %0d, got %0d", name, want_v, got_v);
			mismatches++;
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			got_res = {kind, status, found, event_port, event_pin, last};
			if (replies_due.size() == 0) begin
				$error("result with nothing outstanding: %h", got_res);
				mismatches++;
			end else begin
				want_res = replies_due.pop_front();
				check_field("kind", int'(want_res.kind), int'(got_res.kind));
				check_field("status", int'(want_res.status), int'(got_res.status));
				check_field("found", int'(want_res.found), int'(got_res.found));
				check_field("event_port", int'(want_res.port), int'(got_res.port));
				check_field("event_pin", int'(want_res.pin), int'(got_res.pin));
				check_field("last", int'(want_res.last), int'(got_res.last));
			end
			if (got_res.kind && got_res.found)
				events_seen++;
			else
				replies_seen++;
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CycleLimit) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycles, replies_due.size());
			$display("FAIL gpio_edge_interrupt_controller_top");
			$finish;
		end
	end

endmodule

// ===== filelist.f =====
rtl/geic_pkg.sv
rtl/geic_front.sv
rtl/geic_cmd_fifo.sv
rtl/geic_back.sv
rtl/gpio_edge_interrupt_controller_top.sv
test/gpio_edge_interrupt_controller_top_tb.sv
